FILE: sv/assert_macros.svh
// assertion macros used by the top level rtl file of the ordered map
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked at every rising clock edge out of reset
`define WAVL_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// one condition implies another in the next cycle
`define WAVL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/wavl_pkg.sv
// shared types and constants of the ordered map insert block
// no dependencies
package wavl_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS     = 32;
	localparam int VALUE_BITS   = 32;
	localparam int COUNT_BITS   = 10;

	localparam logic [1:0] ST_NEW  = 2'd0;
	localparam logic [1:0] ST_OCC  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [VALUE_BITS-1:0] old_value;
		logic [COUNT_BITS-1:0] entry_count;
	} result_t;

endpackage

FILE: sv/wavl_node_ram.sv
// node store: one write port, one read port, registered read data
// no dependencies
module wavl_node_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/wavl_ordered_map_insert.sv
// top level of the weak avl ordered map insert block
// depends on wavl_pkg, wavl_node_ram and assert_macros.svh
//
//  channel   dir   signals                           transfer when
//  item      in    item_valid item_ready item        valid & ready
//  result    out   result_valid result_ready result  valid & ready
//  config    in    apb psel penable pwrite paddr     psel & penable & pwrite
//
// work per item: a read and compare for each node on the search path, an append,
// then a promotion step for each level climbed up the tree and at most one rotation,
// all bound by the single read port of the node ram
// reset clears control, root and fill count; the null slot is never written
// and reads as a rank parity of one with null links
// a result waits in its output register; the next item is taken meanwhile
`include "assert_macros.svh"

module wavl_ordered_map_insert #(
	parameter int CAPACITY = wavl_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  wavl_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_ready,
	output wavl_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IW = $clog2(CAPACITY);
	localparam int KB = wavl_pkg::KEY_BITS;
	localparam int VB = wavl_pkg::VALUE_BITS;

	typedef logic [IW-1:0] idx_t;

	typedef struct packed {
		logic [KB-1:0] key;
		logic [VB-1:0] val;
		idx_t          lft;
		idx_t          rgt;
		idx_t          par;
		logic          rp;
	} node_t;

	localparam int NW = $bits(node_t);

	// sequencer codes
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SRCH_RD = 4'd1;
	localparam logic [3:0] S_SRCH_CMP = 4'd2;
	localparam logic [3:0] S_INS_N   = 4'd3;
	localparam logic [3:0] S_INS_P   = 4'd4;
	localparam logic [3:0] S_RB_FLIP = 4'd5;
	localparam logic [3:0] S_RB_GETZ = 4'd6;
	localparam logic [3:0] S_RB_SIB  = 4'd7;
	localparam logic [3:0] S_RT_RD   = 4'd8;
	localparam logic [3:0] S_RT_GET  = 4'd9;
	localparam logic [3:0] S_RT_CALC = 4'd10;
	localparam logic [3:0] S_RT_WR   = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	logic [3:0] state_q;
	logic [KB-1:0] key_q;
	logic [VB-1:0] val_q;
	idx_t seek_q, root_q;
	logic [IW:0] used_q;
	logic sko_q, last_q, leaf_q, d_q, dbl_q;
	logic [2:0] step_q;
	node_t nz_q, nx_q, ny_q, npp_q, nyd_q, nyn_q;
	idx_t iz_q, ix_q, iy_q, ipp_q, iyd_q, iyn_q;
	logic [1:0] stat_q;
	logic [VB-1:0] old_q;
	logic ra_zero_q;
	logic out_valid_q;
	wavl_pkg::result_t out_q;

	// ram ports
	logic ram_we;
	idx_t ram_wa, ram_ra;
	node_t ram_wd;
	logic [NW-1:0] ram_rd;
	node_t rnode;

	wavl_node_ram #(.W(NW), .DEPTH(CAPACITY), .AW(IW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (NW'(ram_wd)),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	// the null slot reads as a parity-one leaf with no links
	always_comb begin
		rnode = node_t'(ram_rd);
		if (ra_zero_q) begin
			rnode = '0;
			rnode.rp = 1'b1;
		end
	end

	function automatic node_t set_ch(node_t n, logic dir, idx_t c);
		node_t r;
		r = n;
		if (dir) r.rgt = c;
		else     r.lft = c;
		return r;
	endfunction

	function automatic idx_t get_ch(node_t n, logic dir);
		return dir ? n.rgt : n.lft;
	endfunction

	// new child on one side, new parent, parity optionally toggled
	function automatic node_t relink_node(node_t n, logic dir, idx_t c, idx_t p, logic flp);
		node_t r;
		r = set_ch(n, dir, c);
		r.par = p;
		r.rp  = n.rp ^ flp;
		return r;
	endfunction

	function automatic node_t promote(node_t n);
		node_t r;
		r = n;
		r.rp = ~n.rp;
		return r;
	endfunction

	// key order, sign bit flipped for two's complement when sko_q is set
	logic [KB-1:0] ka, kb;
	logic k_eq, k_gt;
	assign ka = key_q ^ {sko_q, {(KB-1){1'b0}}};
	assign kb = rnode.key ^ {sko_q, {(KB-1){1'b0}}};
	assign k_eq = (ka == kb);
	assign k_gt = (ka > kb);

	idx_t new_slot;
	assign new_slot = used_q[IW-1:0];

	logic full;
	assign full = (used_q >= (IW+1)'(CAPACITY));

	idx_t sib_idx;
	assign sib_idx = (rnode.lft == ix_q) ? rnode.rgt : rnode.lft;

	// result register takes the finished item
	logic load_out;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || result_ready);

	// read and write port control
	always_comb begin
		ram_we = 1'b0;
		ram_wa = '0;
		ram_wd = nz_q;
		ram_ra = seek_q;
		case (state_q)
			S_SRCH_CMP: begin
				ram_we = k_eq;
				ram_wa = seek_q;
				ram_wd = rnode;
				ram_wd.val = val_q;
			end
			S_INS_N: begin
				ram_we = !full;
				ram_wa = new_slot;
				ram_wd = '{key: key_q, val: val_q, lft: '0, rgt: '0, par: iz_q, rp: 1'b0};
			end
			S_INS_P: begin
				ram_we = 1'b1;
				ram_wa = iz_q;
			end
			S_RB_FLIP: begin
				ram_we = 1'b1;
				ram_wa = iz_q;
				ram_wd.rp = ~nz_q.rp;
				ram_ra = nz_q.par;
			end
			S_RB_GETZ: ram_ra = sib_idx;
			S_RT_RD: begin
				case (step_q)
					3'd0:    ram_ra = iy_q;
					3'd1:    ram_ra = ipp_q;
					3'd2:    ram_ra = iyd_q;
					default: ram_ra = iyn_q;
				endcase
			end
			S_RT_WR: begin
				case (step_q)
					3'd0: begin ram_wa = ix_q;  ram_wd = nx_q;  end
					3'd1: begin ram_wa = iz_q;  ram_wd = nz_q;  end
					3'd2: begin ram_wa = iy_q;  ram_wd = ny_q;  end
					3'd3: begin ram_wa = ipp_q; ram_wd = npp_q; end
					3'd4: begin ram_wa = iyd_q; ram_wd = nyd_q; end
					default: begin ram_wa = iyn_q; ram_wd = nyn_q; end
				endcase
				ram_we = (ram_wa != '0);
			end
			default: ;
		endcase
	end

	assign item_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_q      <= '0;
			used_q      <= (IW+1)'(1);
			out_valid_q <= 1'b0;
			ra_zero_q   <= 1'b0;
			step_q      <= '0;
		end else begin
			ra_zero_q <= (ram_ra == '0);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						key_q   <= item.key;
						val_q   <= item.value;
						seek_q  <= root_q;
						iz_q    <= '0;
						last_q  <= 1'b0;
						old_q   <= '0;
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: begin
					state_q <= (seek_q == '0) ? S_INS_N : S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (k_eq) begin
						// value swapped in by the write port this cycle
						old_q   <= rnode.val;
						stat_q  <= wavl_pkg::ST_OCC;
						state_q <= S_DONE;
					end else begin
						nz_q    <= rnode;
						iz_q    <= seek_q;
						last_q  <= k_gt;
						seek_q  <= get_ch(rnode, k_gt);
						state_q <= S_SRCH_RD;
					end
				end
				S_INS_N: begin
					if (full) begin
						stat_q  <= wavl_pkg::ST_FULL;
						state_q <= S_DONE;
					end else begin
						stat_q <= wavl_pkg::ST_NEW;
						used_q <= used_q + 1'b1;
						if (iz_q == '0) begin
							root_q  <= new_slot;
							state_q <= S_DONE;
						end else begin
							leaf_q  <= (nz_q.lft == '0) && (nz_q.rgt == '0);
							nz_q    <= set_ch(nz_q, last_q, new_slot);
							ix_q    <= new_slot;
							state_q <= S_INS_P;
						end
					end
				end
				S_INS_P: begin
					state_q <= leaf_q ? S_RB_FLIP : S_DONE;
				end
				S_RB_FLIP: begin
					// promote z, then climb: x takes z, z its parent
					nx_q    <= promote(nz_q);
					ix_q    <= iz_q;
					iz_q    <= nz_q.par;
					state_q <= (nz_q.par == '0) ? S_DONE : S_RB_GETZ;
				end
				S_RB_GETZ: begin
					nz_q    <= rnode;
					state_q <= S_RB_SIB;
				end
				S_RB_SIB: begin
					if (nx_q.rp == nz_q.rp && rnode.rp != nz_q.rp) begin
						state_q <= S_RB_FLIP;
					end else if (nx_q.rp == nz_q.rp && nz_q.rp == rnode.rp) begin
						d_q     <= (nz_q.rgt == ix_q);
						iy_q    <= get_ch(nx_q, !(nz_q.rgt == ix_q));
						ipp_q   <= nz_q.par;
						step_q  <= '0;
						state_q <= S_RT_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RT_RD: begin
					state_q <= S_RT_GET;
				end
				S_RT_GET: begin
					case (step_q)
						3'd0: begin
							ny_q  <= rnode;
							dbl_q <= (iy_q != '0) && (rnode.rp != nz_q.rp);
							if ((iy_q != '0) && (rnode.rp != nz_q.rp)) begin
								iyd_q <= get_ch(rnode, d_q);
								iyn_q <= get_ch(rnode, !d_q);
							end else begin
								iyd_q <= '0;
								iyn_q <= '0;
							end
						end
						3'd1:    npp_q <= rnode;
						3'd2:    nyd_q <= rnode;
						default: nyn_q <= rnode;
					endcase
					if (step_q == 3'd3) begin
						state_q <= S_RT_CALC;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_RT_RD;
					end
				end
				S_RT_CALC: begin
					step_q  <= '0;
					state_q <= S_RT_WR;
					if (!dbl_q) begin
						// single rotation: x takes the place of z
						nx_q <= relink_node(nx_q, !d_q, iz_q, ipp_q, 1'b0);
						nz_q <= relink_node(nz_q, d_q, iy_q, ix_q, 1'b1);
						ny_q.par <= iz_q;
						if (ipp_q == '0) root_q <= ix_q;
						else if (npp_q.rgt == iz_q) npp_q.rgt <= ix_q;
						else npp_q.lft <= ix_q;
					end else begin
						// double rotation: y takes the place of z
						ny_q <= '{key: ny_q.key, val: ny_q.val,
							lft: d_q ? iz_q : ix_q, rgt: d_q ? ix_q : iz_q,
							par: ipp_q, rp: ~ny_q.rp};
						nx_q <= relink_node(nx_q, !d_q, iyd_q, iy_q, 1'b1);
						nz_q <= relink_node(nz_q, d_q, iyn_q, iy_q, 1'b1);
						nyd_q.par <= ix_q;
						nyn_q.par <= iz_q;
						if (ipp_q == '0) root_q <= iy_q;
						else if (npp_q.rgt == iz_q) npp_q.rgt <= iy_q;
						else npp_q.lft <= iy_q;
					end
				end
				S_RT_WR: begin
					if (step_q == 3'd5) state_q <= S_DONE;
					else step_q <= step_q + 1'b1;
				end
				S_DONE: begin
					if (!out_valid_q || result_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status      <= stat_q;
			out_q.old_value   <= old_q;
			out_q.entry_count <= wavl_pkg::COUNT_BITS'(used_q - 1'b1);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sko_q <= 1'b0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			sko_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {31'd0, sko_q};

	logic fill_ok;
	assign fill_ok = (used_q >= (IW+1)'(1)) && (used_q <= (IW+1)'(CAPACITY));

	`WAVL_ASSERT(a_no_null_write, !(ram_we && ram_wa == '0), "write to null slot")
	`WAVL_ASSERT(a_fill_range, fill_ok, "fill count out of range")
	`WAVL_ASSERT_NEXT(a_accept_busy, item_valid && item_ready, state_q == S_SRCH_RD, "accept did not start a search")
	`WAVL_ASSERT_NEXT(a_done_loads, load_out, result_valid && item_ready, "result not loaded")

endmodule

FILE: tb/tb_wavl_ordered_map_insert.sv
// self-checking testbench of the weak avl ordered map insert block
// depends on wavl_pkg and the block's rtl; keeps its own mirror of the tree
module tb_wavl_ordered_map_insert;

	localparam int SLOTS       = wavl_pkg::CAPACITY_DEF;
	localparam int KEY_BITS    = wavl_pkg::KEY_BITS;
	localparam int VALUE_BITS  = wavl_pkg::VALUE_BITS;
	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE      = 300;
	localparam logic [2:0] ADDR_ORDER = 3'd0;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	wavl_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	wavl_pkg::result_t result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	wavl_ordered_map_insert DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// mirror of the node store
	logic [KEY_BITS-1:0]   tree_key   [SLOTS];
	logic [VALUE_BITS-1:0] tree_value [SLOTS];
	logic [9:0]            tree_left  [SLOTS];
	logic [9:0]            tree_right [SLOTS];
	logic [9:0]            tree_up    [SLOTS];
	logic                  tree_par   [SLOTS];
	logic [9:0]            tree_root;
	int                    slots_used;
	logic                  order_signed;

	wavl_pkg::result_t     pending_results[$];
	logic [KEY_BITS-1:0]   stored_keys[$];
	int                    errors;
	int                    items_sent;
	int                    results_seen;
	int                    idle_cycles;
	int                    send_idle_pct;
	int                    recv_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [9:0] kid(logic [9:0] n, logic dir);
		return dir ? tree_right[n] : tree_left[n];
	endfunction

	function automatic void set_kid(logic [9:0] n, logic dir, logic [9:0] c);
		if (n == 0)
			return;
		if (dir)
			tree_right[n] = c;
		else
			tree_left[n] = c;
	endfunction

	function automatic void set_up(logic [9:0] n, logic [9:0] p);
		if (n != 0)
			tree_up[n] = p;
	endfunction

	function automatic void toggle_rank(logic [9:0] n);
		if (n != 0)
			tree_par[n] = ~tree_par[n];
	endfunction

	// repoint the link under pp that held old_sub
	function automatic void relink(logic [9:0] pp, logic [9:0] old_sub, logic [9:0] new_sub);
		if (pp == 0)
			tree_root = new_sub;
		else if (tree_right[pp] == old_sub)
			tree_right[pp] = new_sub;
		else
			tree_left[pp] = new_sub;
	endfunction

	// -1, 0, 1 in the current key order
	function automatic int key_cmp(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
		if (order_signed) begin
			a[KEY_BITS-1] = ~a[KEY_BITS-1];
			b[KEY_BITS-1] = ~b[KEY_BITS-1];
		end
		return (a < b) ? -1 : ((a > b) ? 1 : 0);
	endfunction

	// z was a leaf and has just been given child x
	function automatic void restore_balance(logic [9:0] z, logic [9:0] x);
		int guard;
		logic [9:0] sib, y, pp, yd, yn;
		logic d;
		guard = 0;
		forever begin
			toggle_rank(z);
			x = z;
			z = tree_up[x];
			if (z == 0)
				return;
			sib = (tree_left[z] == x) ? tree_right[z] : tree_left[z];
			if (!(tree_par[x] == tree_par[z] && tree_par[sib] != tree_par[z]))
				break;
			guard++;
			if (guard > SLOTS)
				return;
		end
		if (!(tree_par[x] == tree_par[z] && tree_par[z] == tree_par[sib]))
			return;
		d  = (tree_right[z] == x);
		y  = kid(x, !d);
		pp = tree_up[z];
		if (y == 0 || tree_par[y] == tree_par[z]) begin
			// single rotation, x moves up
			set_up(x, pp);
			relink(pp, z, x);
			set_kid(x, !d, z);
			set_up(z, x);
			set_kid(z, d, y);
			set_up(y, z);
			toggle_rank(z);
		end else begin
			// double rotation, y moves up
			yd = kid(y, d);
			yn = kid(y, !d);
			set_up(y, pp);
			relink(pp, z, y);
			set_kid(x, !d, yd);
			set_up(yd, x);
			set_kid(y, d, x);
			set_up(x, y);
			set_kid(z, d, yn);
			set_up(yn, z);
			set_kid(y, !d, z);
			set_up(z, y);
			toggle_rank(y);
			toggle_rank(x);
			toggle_rank(z);
		end
	endfunction

	function automatic wavl_pkg::result_t predict_insert(wavl_pkg::item_t it);
		wavl_pkg::result_t r;
		logic [9:0] seek, parent, n;
		int last, guard;
		logic was_leaf;
		seek = tree_root;
		parent = 0;
		last = 0;
		guard = 0;
		r = '0;
		while (seek != 0 && guard < SLOTS) begin
			last = key_cmp(it.key, tree_key[seek]);
			if (last == 0)
				break;
			parent = seek;
			seek = kid(seek, last > 0);
			guard++;
		end
		if (seek != 0 && last == 0) begin
			r.old_value = tree_value[seek];
			tree_value[seek] = it.value;
			r.status = wavl_pkg::ST_OCC;
		end else if (slots_used >= SLOTS) begin
			r.status = wavl_pkg::ST_FULL;
		end else begin
			n = slots_used[9:0];
			tree_key[n] = it.key;
			tree_value[n] = it.value;
			tree_left[n] = 0;
			tree_right[n] = 0;
			tree_up[n] = 0;
			tree_par[n] = 1'b0;
			slots_used++;
			stored_keys.push_back(it.key);
			if (tree_root == 0 || parent == 0) begin
				tree_root = n;
			end else begin
				was_leaf = (tree_left[parent] == 0 && tree_right[parent] == 0);
				set_kid(parent, last > 0, n);
				tree_up[n] = parent;
				if (was_leaf)
					restore_balance(parent, n);
			end
			r.status = wavl_pkg::ST_NEW;
		end
		r.entry_count = wavl_pkg::COUNT_BITS'(slots_used - 1);
		return r;
	endfunction

	// ---------------------------------------------------------------- checker

	// result side: compare each transfer, randomise ready, run the idle counter
	always @(posedge clk) begin
		wavl_pkg::result_t want;
		if (arst_n) begin
			if ((item_valid && item_ready) || (psel && penable && pready)
				|| (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (result_valid && result_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, actual %p", $time, result);
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result.status);
					end
					if (result.old_value !== want.old_value) begin
						errors++;
						$display("%0t: old_value expected %h actual %h",
							$time, want.old_value, result.old_value);
					end
					if (result.entry_count !== want.entry_count) begin
						errors++;
						$display("%0t: entry_count expected %0d actual %0d",
							$time, want.entry_count, result.entry_count);
					end
				end
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// ---------------------------------------------------------------- drivers

	// one item transfer; valid only drops when the sender chooses to idle
	task automatic send_entry(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{key: k, value: v};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		pending_results.push_back(predict_insert('{key: k, value: v}));
		items_sent++;
	endtask

	// hold off until every result is back and the block has settled
	task automatic drain_block();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write of the key order, then read back
	task automatic write_order(logic v);
		drain_block();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_ORDER; pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		order_signed = v;
		pwrite <= 1'b0; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== v) begin
			errors++;
			$display("%0t: key order read expected %0d actual %0d", $time, v, prdata[0]);
		end
		psel <= 1'b0; penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_stored();
		return stored_keys[$urandom_range(stored_keys.size() - 1)];
	endfunction

	// ---------------------------------------------------------------- tests

	// field extremes, replacement, ascending and zigzag runs for rotations
	task automatic test_directed();
		write_order(1'b0);
		send_entry(32'h0000_0000, 32'h0000_0000);
		send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_entry(32'h8000_0000, 32'hA5A5_A5A5);
		send_entry(32'h7FFF_FFFF, 32'h5A5A_5A5A);
		send_entry(32'h0000_0000, 32'h1234_5678);  // replace
		send_entry(32'hFFFF_FFFF, 32'h0000_0000);  // replace with zero
		for (int i = 1; i <= 6; i++)
			send_entry(32'h100 + i, i);            // ascending, single rotations
		send_entry(32'h200, 32'd1);
		send_entry(32'h180, 32'd2);                // zigzag, double rotation
		send_entry(32'h1C0, 32'd3);
		send_entry(32'h0000_0001, 32'hDEAD_BEEF);
	endtask

	// signed order over a tree built unsigned, then fresh signed inserts
	task automatic test_signed_order();
		write_order(1'b1);
		send_entry(32'h8000_0000, 32'h0BAD_F00D);  // searches now follow signed order
		send_entry(32'hFFFF_FFFE, 32'd7);
		send_entry(32'h8000_0001, 32'd8);
		send_entry(32'h7FFF_FFFE, 32'd9);
		send_entry(32'hFFFF_FFFE, 32'hCAFE_0000);
		send_entry(32'h0000_0005, 32'd10);
	endtask

	// mostly new keys, some replacements, with a full drain now and then
	task automatic test_random(int s_pct, int r_pct, logic ord, int count);
		logic [KEY_BITS-1:0] k;
		write_order(ord);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2: k = pick_stored();
				3:       k = $urandom_range(63);
				default: k = $urandom;
			endcase
			send_entry(k, $urandom);
			if (i % 120 == 119)
				drain_block();
		end
	endtask

	// fill every slot, then absent keys report full and present keys still replace
	task automatic test_store_full();
		send_idle_pct = 5;
		recv_idle_pct = 5;
		while (slots_used < SLOTS)
			send_entry($urandom, $urandom);
		for (int i = 0; i < 12; i++) begin
			if (i % 3 == 0)
				send_entry(pick_stored(), $urandom);
			else
				send_entry($urandom, $urandom);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		paddr = '0; pwdata = '0;
		errors = 0; items_sent = 0; results_seen = 0; idle_cycles = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		tree_root = 0;
		slots_used = 1;
		order_signed = 1'b0;
		tree_par[0] = 1'b1;
		tree_left[0] = 0; tree_right[0] = 0; tree_up[0] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_signed_order();
		test_random(17, 76, 1'b0, 330);
		test_random(76, 17, 1'b1, 330);
		test_random(0, 0, 1'b0, 330);
		test_store_full();
		drain_block();

		$display("%0d items sent, %0d results checked, %0d entries at the end",
			items_sent, results_seen, slots_used - 1);
		$display("covered both key orders, order switches on a live tree and a full store");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/wavl_pkg.sv
sv/wavl_node_ram.sv
sv/wavl_ordered_map_insert.sv
tb/tb_wavl_ordered_map_insert.sv
